// ===== rtl/hot_pkg.sv =====
// hot_pkg: shared types and codes for the horizon occlusion test block
// used by hot_isqrt, hot_div and horizon_occlusion_test_top
`default_nettype none
package hot_pkg;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // sequencer states
  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MUL  = 7'b0000010,
    ST_SQ1  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_HBSQ = 7'b0010000,
    ST_SQ2  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  // multiplier operations, issued in this order
  typedef logic [3:0] op_t;
  localparam op_t OP_EXX = 4'd0;
  localparam op_t OP_EYY = 4'd1;
  localparam op_t OP_EZZ = 4'd2;
  localparam op_t OP_RQQ = 4'd3;
  localparam op_t OP_RR  = 4'd4;
  localparam op_t OP_DXX = 4'd5;
  localparam op_t OP_DYY = 4'd6;
  localparam op_t OP_DZZ = 4'd7;
  localparam op_t OP_EXD = 4'd8;
  localparam op_t OP_EYD = 4'd9;
  localparam op_t OP_EZD = 4'd10;
  localparam op_t OP_HB  = 4'd11;

  // register map
  localparam logic [1:0] REG_EYE_X  = 2'd0;
  localparam logic [1:0] REG_EYE_Y  = 2'd1;
  localparam logic [1:0] REG_EYE_Z  = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/horizon_occlusion_test_top.sv =====
// horizon_occlusion_test_top: horizon culling of bound points against a sphere
// depends on hot_pkg, hot_mul, hot_isqrt, hot_div
//
// usage:
// - s_* stream carries one bound point per transaction; the center comes first
//   (s_tuser[0] = first point), s_tlast marks the final point of a bound
// - m_* stream carries one result per bound, m_tdata[0] = fully hidden,
//   issued on the transaction that had s_tlast set
// - apb port writes eye_x, eye_y, eye_z and occluder radius; write only while
//   the block is idle
// - each point runs through these steps: the idle state in which it is taken,
//   the shared multiplier (eye, radius, delta squares and dot products), a
//   square root for the segment length, a divide for the projection, its
//   square on the shared multiplier, a second square root and a finish state;
//   early outs end sooner, when caught after the products, at a zero length
//   or after the projection square
// - s_tready is high only while no point is in work
// - a result waits in the output register; the next point is taken and
//   computed meanwhile, and only a finishing last point holds for m_tready
// - synchronous reset clears the bound state to all hidden and valid, clears
//   the eye and radius registers and drops m_tvalid
`default_nettype none
module horizon_occlusion_test_top #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 12
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // apb config
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0] paddr,
  input  wire logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0] pwdata,
  output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]   prdata,
  output logic                                        pready,
  // point stream
  input  wire logic                                   s_tvalid,
  output logic                                        s_tready,
  // s_tdata: point_x, point_y, point_z, zero pad
  input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  input  wire logic                                   s_tlast,   // last_point
  // s_tuser: first_point, bound_valid
  input  wire logic [1:0]                             s_tuser,
  // result stream
  output logic                                        m_tvalid,
  input  wire logic                                   m_tready,
  // m_tdata: fully_hidden, zero pad
  output logic [7:0]                                  m_tdata
);

  localparam int W    = COORD_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int PDW  = (W > 32) ? 64 : 32;
  localparam int PAW  = (W > 32) ? 5 : 4;
  localparam int ASH  = (W > 32) ? 3 : 2;
  localparam int MW   = W + 2;          // multiplier operand width
  localparam int AW   = 2 * MW;         // product and accumulator width
  localparam int R    = AW / 2;         // square root width
  localparam int QW   = W + 2;          // quotient width
  localparam int TW   = W + 5;          // root candidate width
  localparam longint unsigned THR = ((64'd1 << (2 * F)) + 64'd99999999) / 64'd100000000;
  localparam longint unsigned LIM = (64'd1 << F) / 64'd1000;
  localparam longint unsigned RADJ = 64'd1 << (F - 2);

  // config registers
  logic [W-1:0]   eye_x, eye_y, eye_z;
  logic [W-2:0]   radius;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PAW-1:ASH];

  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x  <= '0;
      eye_y  <= '0;
      eye_z  <= '0;
      radius <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        hot_pkg::REG_EYE_X:  eye_x  <= pwdata[W-1:0];
        hot_pkg::REG_EYE_Y:  eye_y  <= pwdata[W-1:0];
        hot_pkg::REG_EYE_Z:  eye_z  <= pwdata[W-1:0];
        hot_pkg::REG_RADIUS: radius <= pwdata[W-2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hot_pkg::REG_EYE_X:  prdata = PDW'(eye_x);
      hot_pkg::REG_EYE_Y:  prdata = PDW'(eye_y);
      hot_pkg::REG_EYE_Z:  prdata = PDW'(eye_z);
      hot_pkg::REG_RADIUS: prdata = PDW'(radius);
      default:             prdata = '0;
    endcase
  end

  // sequencer state
  hot_pkg::state_t state;
  hot_pkg::op_t    cnt;
  hot_pkg::op_t    op_sel;
  hot_pkg::op_t    op_prev;

  // latched point
  logic [W-1:0] px, py, pz;
  logic         pf, pl, pv;

  // bound state
  logic ah, vs;

  // intermediate results
  logic [AW-1:0]        esq, rqsq, rsq, lsq;
  logic signed [AW-1:0] dot;
  logic [R-1:0]         len;
  logic [QW-1:0]        hbm;
  logic                 hidden;

  assign s_tready = (state == hot_pkg::ST_IDLE);

  // shared multiplier operand select
  logic signed [W:0]    dx, dy, dz;
  logic [W-1:0]         rq;
  logic signed [MW-1:0] ma, mb;
  logic signed [AW-1:0] prod;

  assign dx = $signed({px[W-1], px}) - $signed({eye_x[W-1], eye_x});
  assign dy = $signed({py[W-1], py}) - $signed({eye_y[W-1], eye_y});
  assign dz = $signed({pz[W-1], pz}) - $signed({eye_z[W-1], eye_z});
  assign rq = W'(radius) + W'(RADJ);

  assign op_sel = (state == hot_pkg::ST_HBSQ) ? hot_pkg::OP_HB : cnt;

  always_comb begin
    unique case (op_sel)
      hot_pkg::OP_EXX: begin ma = MW'($signed(eye_x)); mb = MW'($signed(eye_x)); end
      hot_pkg::OP_EYY: begin ma = MW'($signed(eye_y)); mb = MW'($signed(eye_y)); end
      hot_pkg::OP_EZZ: begin ma = MW'($signed(eye_z)); mb = MW'($signed(eye_z)); end
      hot_pkg::OP_RQQ: begin ma = $signed(MW'(rq)); mb = $signed(MW'(rq)); end
      hot_pkg::OP_RR:  begin ma = $signed(MW'(radius)); mb = $signed(MW'(radius)); end
      hot_pkg::OP_DXX: begin ma = MW'(dx); mb = MW'(dx); end
      hot_pkg::OP_DYY: begin ma = MW'(dy); mb = MW'(dy); end
      hot_pkg::OP_DZZ: begin ma = MW'(dz); mb = MW'(dz); end
      hot_pkg::OP_EXD: begin ma = MW'($signed(eye_x)); mb = MW'(dx); end
      hot_pkg::OP_EYD: begin ma = MW'($signed(eye_y)); mb = MW'(dy); end
      hot_pkg::OP_EZD: begin ma = MW'($signed(eye_z)); mb = MW'(dz); end
      hot_pkg::OP_HB:  begin ma = $signed(MW'(hbm)); mb = $signed(MW'(hbm)); end
      default:         begin ma = '0; mb = '0; end
    endcase
  end

  hot_mul #(.MW(MW)) u_mul (
    .clk (clk),
    .a   (ma),
    .b   (mb),
    .p   (prod)
  );

  // early-out checks once all products are in
  logic          early_fail;
  logic [AW-1:0] cval;
  logic          hb_gt_c;
  logic          negdot;

  assign early_fail = (radius == '0) || (esq <= rqsq) || (lsq < AW'(THR));
  assign cval       = esq - rsq;
  assign hb_gt_c    = $unsigned(prod) > cval;
  assign negdot     = dot[AW-1];

  // shared square root, used for segment length and for the chord
  logic               sq_start;
  logic [AW-1:0]      sq_in;
  logic [R-1:0]       sq_root;
  hot_pkg::unit_sts_t sq_sts;

  always_comb begin
    sq_start = 1'b0;
    sq_in    = lsq;
    if (state == hot_pkg::ST_MUL) begin
      sq_start = (cnt == hot_pkg::OP_HB) && !early_fail;
    end else if (state == hot_pkg::ST_HBSQ) begin
      sq_start = (cnt != hot_pkg::OP_EXX) && hb_gt_c;
      sq_in    = $unsigned(prod) - cval;
    end
  end

  hot_isqrt #(.N(AW)) u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .rad   (sq_in),
    .root  (sq_root),
    .sts   (sq_sts)
  );

  // projection divide |E.D| / len
  logic               dv_start;
  logic [AW-1:0]      dv_num;
  logic [QW-1:0]      dv_quo;
  hot_pkg::unit_sts_t dv_sts;

  assign dv_start = (state == hot_pkg::ST_SQ1) && sq_sts.done && (sq_root != '0);
  assign dv_num   = negdot ? $unsigned(-dot) : $unsigned(dot);

  hot_div #(.DVW(R), .QW(QW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (dv_num),
    .den   (sq_root),
    .quo   (dv_quo),
    .sts   (dv_sts)
  );

  // root hit test: t > floor(2^F/1000) and len - t > floor(2^F/1000)
  logic signed [TW-1:0] hbs, t0, t1, lenw, lims;
  logic                 hit0, hit1;

  assign hbs  = negdot ? -$signed(TW'(hbm)) : $signed(TW'(hbm));
  assign t0   = -hbs - $signed(TW'(sq_root));
  assign t1   = -hbs + $signed(TW'(sq_root));
  assign lenw = $signed(TW'(len));
  assign lims = $signed(TW'(LIM));
  assign hit0 = (t0 > lims) && ((lenw - t0) > lims);
  assign hit1 = (t1 > lims) && ((lenw - t1) > lims);

  // bound state update at finish
  logic ah_new, vs_new;
  assign ah_new = (pf | ah) & hidden;
  assign vs_new = (pf | vs) & pv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= hot_pkg::ST_IDLE;
      cnt      <= hot_pkg::OP_EXX;
      ah       <= 1'b1;
      vs       <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      op_prev <= op_sel;
      // a finishing last point reloads the output register in the same cycle
      if (m_tvalid && m_tready && !(state == hot_pkg::ST_FIN && pl)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        hot_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            px    <= s_tdata[W-1:0];
            py    <= s_tdata[2*W-1:W];
            pz    <= s_tdata[3*W-1:2*W];
            pf    <= s_tuser[0];
            pv    <= s_tuser[1];
            pl    <= s_tlast;
            cnt   <= hot_pkg::OP_EXX;
            state <= hot_pkg::ST_MUL;
          end
        end
        hot_pkg::ST_MUL: begin
          // collect the product issued in the previous cycle
          if (cnt != hot_pkg::OP_EXX) begin
            unique case (op_prev)
              hot_pkg::OP_EXX: esq  <= $unsigned(prod);
              hot_pkg::OP_EYY,
              hot_pkg::OP_EZZ: esq  <= esq + $unsigned(prod);
              hot_pkg::OP_RQQ: rqsq <= $unsigned(prod);
              hot_pkg::OP_RR:  rsq  <= $unsigned(prod);
              hot_pkg::OP_DXX: lsq  <= $unsigned(prod);
              hot_pkg::OP_DYY,
              hot_pkg::OP_DZZ: lsq  <= lsq + $unsigned(prod);
              hot_pkg::OP_EXD: dot  <= prod;
              hot_pkg::OP_EYD,
              hot_pkg::OP_EZD: dot  <= dot + prod;
              default: ;
            endcase
          end
          if (cnt == hot_pkg::OP_HB) begin
            if (early_fail) begin
              hidden <= 1'b0;
              state  <= hot_pkg::ST_FIN;
            end else begin
              state <= hot_pkg::ST_SQ1;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        hot_pkg::ST_SQ1: begin
          if (sq_sts.done) begin
            len <= sq_root;
            if (sq_root == '0) begin
              hidden <= 1'b0;
              state  <= hot_pkg::ST_FIN;
            end else begin
              state <= hot_pkg::ST_DIV;
            end
          end
        end
        hot_pkg::ST_DIV: begin
          if (dv_sts.done) begin
            hbm   <= dv_quo;
            cnt   <= hot_pkg::OP_EXX;
            state <= hot_pkg::ST_HBSQ;
          end
        end
        hot_pkg::ST_HBSQ: begin
          // on entry it issues hb*hb, then it takes the registered product
          if (cnt == hot_pkg::OP_EXX) begin
            cnt <= hot_pkg::OP_EYY;
          end else if (hb_gt_c) begin
            state <= hot_pkg::ST_SQ2;
          end else begin
            hidden <= 1'b0;
            state  <= hot_pkg::ST_FIN;
          end
        end
        hot_pkg::ST_SQ2: begin
          if (sq_sts.done) begin
            hidden <= hit0 | hit1;
            state  <= hot_pkg::ST_FIN;
          end
        end
        hot_pkg::ST_FIN: begin
          // a last point holds here while an earlier result is still unread
          if (!(pl && m_tvalid && !m_tready)) begin
            if (pl) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {7'd0, ah_new & vs_new};
              ah       <= 1'b1;
              vs       <= 1'b1;
            end else begin
              ah <= ah_new;
              vs <= vs_new;
            end
            state <= hot_pkg::ST_IDLE;
          end
        end
        default: state <= hot_pkg::ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hot_mul.sv =====
// hot_mul: shared signed multiplier with registered product
// no dependencies
`default_nettype none
module hot_mul #(
  parameter int MW = 34
) (
  input  wire logic                 clk,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic signed [2*MW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ===== rtl/hot_isqrt.sv =====
// hot_isqrt: iterative integer square root, one result bit per cycle
// depends on hot_pkg
`default_nettype none
module hot_isqrt #(
  parameter int N = 68
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [N-1:0]    rad,
  output logic [N/2-1:0]       root,
  output hot_pkg::unit_sts_t   sts
);

  localparam int R  = N / 2;
  localparam int CW = $clog2(R);

  logic [N-1:0]  x;
  logic [N-1:0]  res;
  logic [N-1:0]  one;
  logic [CW-1:0] cnt;
  logic [N-1:0]  sum;

  assign sum  = res + one;
  assign root = res[R-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
    end else begin
      sts.done <= 1'b0;
      if (start) begin
        x        <= rad;
        res      <= '0;
        one      <= N'(1) << (N - 2);
        cnt      <= '0;
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        if (x >= sum) begin
          x   <= x - sum;
          res <= (res >> 1) + one;
        end else begin
          res <= res >> 1;
        end
        one <= one >> 2;
        cnt <= cnt + CW'(1);
        if (cnt == CW'(R - 1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hot_div.sv =====
// hot_div: restoring divider, one quotient bit per cycle
// depends on hot_pkg; numerator must be below den * 2^QW
`default_nettype none
module hot_div #(
  parameter int DVW = 34,
  parameter int QW  = 34
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DVW+QW-1:0] num,
  input  wire logic [DVW-1:0]    den,
  output logic [QW-1:0]          quo,
  output hot_pkg::unit_sts_t     sts
);

  localparam int CW = $clog2(QW);

  logic [DVW-1:0] rem;
  logic [DVW-1:0] dreg;
  logic [CW-1:0]  cnt;
  logic [DVW:0]   trial;
  logic           ge;

  assign trial = {rem, quo[QW-1]};
  assign ge    = trial >= {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      sts <= '0;
    end else begin
      sts.done <= 1'b0;
      if (start) begin
        rem      <= num[DVW+QW-1:QW];
        quo      <= num[QW-1:0];
        dreg     <= den;
        cnt      <= '0;
        sts.busy <= 1'b1;
      end else if (sts.busy) begin
        rem <= ge ? DVW'(trial - {1'b0, dreg}) : trial[DVW-1:0];
        quo <= {quo[QW-2:0], ge};
        cnt <= cnt + CW'(1);
        if (cnt == CW'(QW - 1)) begin
          sts.busy <= 1'b0;
          sts.done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
